### rtl/fse_pkg.sv
package fse_pkg;

    localparam logic [2:0] STG_ATTACK  = 3'd0;
    localparam logic [2:0] STG_DECAY   = 3'd1;
    localparam logic [2:0] STG_SUSTAIN = 3'd2;
    localparam logic [2:0] STG_RELEASE = 3'd3;
    localparam logic [2:0] STG_DONE    = 3'd4;

    localparam logic [2:0] CFG_ATTACK_LEVEL  = 3'd0;
    localparam logic [2:0] CFG_DECAY_LEVEL   = 3'd1;
    localparam logic [2:0] CFG_SUSTAIN_LEVEL = 3'd2;
    localparam logic [2:0] CFG_BASE_LEVEL    = 3'd3;
    localparam logic [2:0] CFG_ATTACK_TICKS  = 3'd4;
    localparam logic [2:0] CFG_DECAY_TICKS   = 3'd5;
    localparam logic [2:0] CFG_SUSTAIN_TICKS = 3'd6;
    localparam logic [2:0] CFG_RELEASE_TICKS = 3'd7;

    localparam logic [1:0] SLP_ATTACK  = 2'd0;
    localparam logic [1:0] SLP_DECAY   = 2'd1;
    localparam logic [1:0] SLP_SUSTAIN = 2'd2;
    localparam logic [1:0] SLP_RELEASE = 2'd3;

    localparam logic       OP_ADVANCE = 1'b0;
    localparam logic       OP_RESTART = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_DIV
    } t_state;

    typedef struct packed {
        logic       advance;
        logic       restart;
        logic       div_start;
        logic       div_step;
        logic       out_load;
        logic       key;
        logic [1:0] slope_idx;
    } t_cmd;

    typedef struct packed {
        logic div_last;
    } t_stat;

endpackage

### rtl/four_stage_envelope_generator.sv
// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_ready    i_op, i_key_held
// result    out        o_out_valid / i_out_ready  o_amplitude, o_stage
// config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// an advance tick's result is registered and shows in the cycle after its transfer
// a restart runs four slope divisions on one shared restoring divider, one
// quotient bit per cycle, before it gives its result
// an item is taken only when no slope division runs and the result register is free
// or its result transfers in the same cycle
// synchronous active-low reset restores the register defaults and clears the state
module four_stage_envelope_generator
    import fse_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic        i_key_held,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_amplitude,
    output logic [2:0]  o_stage,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    fse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_key_held  (i_key_held),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    fse_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_amplitude (o_amplitude),
        .o_stage     (o_stage)
    );

endmodule

### rtl/fse_ctrl.sv
module fse_ctrl
    import fse_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_op,
    input  logic  i_key_held,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    t_state     r_state, n_state;
    logic [1:0] r_idx, n_idx;
    logic       r_out_valid, n_out_valid;
    logic       accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= SLP_ATTACK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state         = r_state;
        n_idx           = r_idx;
        o_cmd           = '0;
        o_cmd.key       = i_key_held;
        o_cmd.slope_idx = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_op == OP_RESTART) begin
                        o_cmd.restart = 1'b1;
                        n_idx         = SLP_ATTACK;
                        n_state       = ST_START;
                    end else begin
                        o_cmd.advance  = 1'b1;
                        o_cmd.out_load = 1'b1;
                    end
                end
            end
            ST_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    if (r_idx == SLP_RELEASE) begin
                        o_cmd.out_load = 1'b1;
                        n_state        = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + 2'd1;
                        n_state = ST_START;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_busy_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !r_out_valid)
        else $error("result pending while slopes are computed");

    a_restart_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_op == OP_RESTART) |=> (r_state == ST_START && r_idx == SLP_ATTACK))
        else $error("restart did not begin with the attack slope");

    a_last_slope_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && i_stat.div_last && r_idx == SLP_RELEASE)
        |=> (r_out_valid && r_state == ST_IDLE))
        else $error("no result after the last slope");
`endif

endmodule

### rtl/fse_datapath.sv
module fse_datapath
    import fse_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic [15:0] o_amplitude,
    output logic [2:0]  o_stage
);

    localparam int AW = 16 + FRAC_BITS;
    localparam int QW = 16 + FRAC_BITS;
    localparam int SW = QW + 1;
    localparam int CW = $clog2(QW);
    localparam logic [AW-1:0] TOP = {16'hFFFF, {FRAC_BITS{1'b0}}};

    function automatic logic [15:0] eff_ticks(input logic [15:0] t);
        return (t == 16'd0) ? 16'd1 : t;
    endfunction

    logic [15:0] r_lvl_attack, r_lvl_decay, r_lvl_sustain, r_lvl_base;
    logic [15:0] r_tk_attack, r_tk_decay, r_tk_sustain, r_tk_release;

    logic [SW-1:0] r_slope [4];
    logic [AW-1:0] r_accum, n_accum;
    logic [15:0]   r_tick, n_tick;
    logic [2:0]    r_stage, n_stage;

    logic [15:0]   r_rem, r_dvs;
    logic [QW-1:0] r_quo;
    logic          r_neg;
    logic [CW-1:0] r_cnt;

    logic [15:0]   r_amp;
    logic [2:0]    r_stage_out;

    // divider operand selection
    logic [15:0] from_lvl, to_lvl, div_ticks, div_mag;
    logic        div_neg;
    logic [16:0] trial;
    logic        fits;
    logic [15:0] rem_next;
    logic [QW-1:0] quo_next;
    logic [SW-1:0] q_ext, slope_new;

    // tick arithmetic
    logic [SW-1:0]        sel_slope;
    logic signed [AW+1:0] sum;
    logic [AW-1:0]        clamped;
    logic [15:0]          tick_inc, eff_cur, t_sus;

    always_comb begin
        case (i_cmd.slope_idx)
            SLP_ATTACK: begin
                from_lvl  = r_lvl_base;
                to_lvl    = r_lvl_attack;
                div_ticks = r_tk_attack;
            end
            SLP_DECAY: begin
                from_lvl  = r_lvl_attack;
                to_lvl    = r_lvl_decay;
                div_ticks = r_tk_decay;
            end
            SLP_SUSTAIN: begin
                from_lvl  = r_lvl_decay;
                to_lvl    = r_lvl_sustain;
                div_ticks = r_tk_sustain;
            end
            default: begin
                from_lvl  = r_lvl_sustain;
                to_lvl    = r_lvl_base;
                div_ticks = r_tk_release;
            end
        endcase
        div_neg   = to_lvl < from_lvl;
        div_mag   = div_neg ? (from_lvl - to_lvl) : (to_lvl - from_lvl);

        // restoring division, one quotient bit per cycle
        trial     = {r_rem, r_quo[QW-1]};
        fits      = trial >= {1'b0, r_dvs};
        rem_next  = fits ? 16'(trial - {1'b0, r_dvs}) : trial[15:0];
        quo_next  = {r_quo[QW-2:0], fits};
        q_ext     = {1'b0, quo_next};
        slope_new = r_neg ? (SW'(0) - q_ext) : q_ext;
    end

    assign o_stat.div_last = (r_cnt == CW'(QW - 1));

    always_comb begin
        case (r_stage[1:0])
            SLP_ATTACK:  eff_cur = eff_ticks(r_tk_attack);
            SLP_DECAY:   eff_cur = eff_ticks(r_tk_decay);
            SLP_SUSTAIN: eff_cur = eff_ticks(r_tk_sustain);
            default:     eff_cur = eff_ticks(r_tk_release);
        endcase
        sel_slope = r_slope[r_stage[1:0]];
        sum       = $signed({2'b00, r_accum}) + $signed({sel_slope[SW-1], sel_slope});
        if (sum[AW+1]) begin
            clamped = '0;
        end else if (sum[AW:0] > {1'b0, TOP}) begin
            clamped = TOP;
        end else begin
            clamped = sum[AW-1:0];
        end
        tick_inc = r_tick + 16'd1;
        t_sus    = r_tick;

        n_accum = r_accum;
        n_tick  = r_tick;
        n_stage = r_stage;
        if (i_cmd.restart) begin
            n_accum = {r_lvl_base, {FRAC_BITS{1'b0}}};
            n_tick  = '0;
            n_stage = STG_ATTACK;
        end else if (i_cmd.advance) begin
            case (r_stage)
                STG_ATTACK, STG_DECAY, STG_RELEASE: begin
                    n_accum = clamped;
                    if (tick_inc >= eff_cur) begin
                        n_tick  = '0;
                        n_stage = r_stage + 3'd1;
                    end else begin
                        n_tick = tick_inc;
                    end
                end
                STG_SUSTAIN: begin
                    // ramp stops after its ticks, then holds while the key is down
                    if (r_tick < eff_cur) begin
                        n_accum = clamped;
                        t_sus   = tick_inc;
                    end
                    n_tick = t_sus;
                    if (t_sus >= eff_cur && !i_cmd.key) begin
                        n_tick  = '0;
                        n_stage = STG_RELEASE;
                    end
                end
                STG_DONE: begin
                    n_accum = '0;
                end
                default: begin
                    n_accum = r_accum;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl_attack  <= 16'd65535;
            r_lvl_decay   <= 16'd49152;
            r_lvl_sustain <= 16'd32768;
            r_lvl_base    <= 16'd0;
            r_tk_attack   <= 16'd1024;
            r_tk_decay    <= 16'd1024;
            r_tk_sustain  <= 16'd1024;
            r_tk_release  <= 16'd1024;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ATTACK_LEVEL:  r_lvl_attack  <= i_cfg_data;
                CFG_DECAY_LEVEL:   r_lvl_decay   <= i_cfg_data;
                CFG_SUSTAIN_LEVEL: r_lvl_sustain <= i_cfg_data;
                CFG_BASE_LEVEL:    r_lvl_base    <= i_cfg_data;
                CFG_ATTACK_TICKS:  r_tk_attack   <= i_cfg_data;
                CFG_DECAY_TICKS:   r_tk_decay    <= i_cfg_data;
                CFG_SUSTAIN_TICKS: r_tk_sustain  <= i_cfg_data;
                CFG_RELEASE_TICKS: r_tk_release  <= i_cfg_data;
                default:           r_lvl_base    <= r_lvl_base;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= '0;
            r_tick  <= '0;
            r_stage <= STG_ATTACK;
            for (int k = 0; k < 4; k++) begin
                r_slope[2'(k)] <= '0;
            end
        end else begin
            r_accum <= n_accum;
            r_tick  <= n_tick;
            r_stage <= n_stage;
            if (i_cmd.div_step && o_stat.div_last) begin
                r_slope[i_cmd.slope_idx] <= slope_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_quo <= {div_mag, {FRAC_BITS{1'b0}}};
            r_dvs <= eff_ticks(div_ticks);
            r_neg <= div_neg;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_next;
            r_quo <= quo_next;
            r_cnt <= r_cnt + CW'(1);
        end
        if (i_cmd.out_load) begin
            r_amp       <= n_accum[AW-1:FRAC_BITS];
            r_stage_out <= n_stage;
        end
    end

    assign o_amplitude = r_amp;
    assign o_stage     = r_stage_out;

`ifndef SYNTHESIS
    a_accum_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_accum[AW-1:FRAC_BITS]) |-> (r_accum[FRAC_BITS-1:0] == '0))
        else $error("accumulator above full scale");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_dvs))
        else $error("divider remainder out of range");

    a_restart_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.restart |=> (r_stage == STG_ATTACK && r_tick == 16'd0
                           && r_accum[AW-1:FRAC_BITS] == r_lvl_base))
        else $error("restart did not load the start state");
`endif

endmodule

### verif/four_stage_envelope_generator_tb.sv
module four_stage_envelope_generator_tb;
    import fse_pkg::*;

    localparam int FRAC_BITS   = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 205;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_CYCLES = 150;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    logic        i_op        = OP_ADVANCE;
    logic        i_key_held  = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_amplitude;
    logic [2:0]  o_stage;
    logic        i_cfg_we    = 1'b0;
    logic [2:0]  i_cfg_index = CFG_ATTACK_LEVEL;
    logic [15:0] i_cfg_data  = 16'd0;

    bit          no_idle   = 1'b0;
    bit          long_hold = 1'b0;
    int          n_settings = 0;
    logic [15:0] next_regs [8];

    class envelope_scoreboard;
        logic [15:0] regs [8];
        logic [2:0]  stage_q;
        logic [15:0] ticks_q;
        longint      accum_q;
        longint      slope_q [4];
        logic [15:0] amp_expected [$];
        logic [2:0]  stage_expected [$];
        int          n_errors;
        int          n_inputs;
        int          n_restarts;
        int          n_checked;
        int          n_finished;

        function new();
            int i;
            regs[CFG_ATTACK_LEVEL]  = 16'd65535;
            regs[CFG_DECAY_LEVEL]   = 16'd49152;
            regs[CFG_SUSTAIN_LEVEL] = 16'd32768;
            regs[CFG_BASE_LEVEL]    = 16'd0;
            for (i = CFG_ATTACK_TICKS; i <= CFG_RELEASE_TICKS; i++)
                regs[3'(i)] = 16'd1024;
            stage_q = STG_ATTACK;
            ticks_q = 16'd0;
            accum_q = 0;
            for (i = SLP_ATTACK; i <= SLP_RELEASE; i++)
                slope_q[2'(i)] = 0;
            n_errors   = 0;
            n_inputs   = 0;
            n_restarts = 0;
            n_checked  = 0;
            n_finished = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] data);
            regs[idx] = data;
        endfunction

        function int pending();
            return amp_expected.size();
        endfunction

        // a ticks register of zero counts as one
        function longint ticks_of(logic [1:0] seg);
            longint t;
            t = longint'(regs[CFG_ATTACK_TICKS + seg]);
            return (t == 0) ? 1 : t;
        endfunction

        function longint slope_between(longint from_lvl, longint to_lvl, longint tick_n);
            if (from_lvl >= to_lvl)
                return ((from_lvl - to_lvl) <<< FRAC_BITS) / tick_n;
            return -(((to_lvl - from_lvl) <<< FRAC_BITS) / tick_n);
        endfunction

        function void add_slope(longint s);
            longint top;
            top = longint'(65535) <<< FRAC_BITS;
            accum_q = accum_q + s;
            if (accum_q < 0)
                accum_q = 0;
            if (accum_q > top)
                accum_q = top;
        endfunction

        function void note_input(logic op, logic key);
            n_inputs++;
            if (op == OP_RESTART) begin
                n_restarts++;
                slope_q[SLP_ATTACK] = slope_between(longint'(regs[CFG_ATTACK_LEVEL]),
                    longint'(regs[CFG_BASE_LEVEL]), ticks_of(SLP_ATTACK));
                slope_q[SLP_DECAY] = -slope_between(longint'(regs[CFG_ATTACK_LEVEL]),
                    longint'(regs[CFG_DECAY_LEVEL]), ticks_of(SLP_DECAY));
                slope_q[SLP_SUSTAIN] = -slope_between(longint'(regs[CFG_DECAY_LEVEL]),
                    longint'(regs[CFG_SUSTAIN_LEVEL]), ticks_of(SLP_SUSTAIN));
                slope_q[SLP_RELEASE] = -slope_between(longint'(regs[CFG_SUSTAIN_LEVEL]),
                    longint'(regs[CFG_BASE_LEVEL]), ticks_of(SLP_RELEASE));
                stage_q = STG_ATTACK;
                ticks_q = 16'd0;
                accum_q = longint'(regs[CFG_BASE_LEVEL]) <<< FRAC_BITS;
            end else begin
                case (stage_q)
                    STG_ATTACK, STG_DECAY, STG_RELEASE: begin
                        add_slope(slope_q[stage_q[1:0]]);
                        ticks_q = ticks_q + 16'd1;
                        if (longint'(ticks_q) >= ticks_of(stage_q[1:0])) begin
                            ticks_q = 16'd0;
                            stage_q = stage_q + 3'd1;
                        end
                    end
                    STG_SUSTAIN: begin
                        // ramp stops after its ticks, then holds while the key is down
                        if (longint'(ticks_q) < ticks_of(SLP_SUSTAIN)) begin
                            add_slope(slope_q[SLP_SUSTAIN]);
                            ticks_q = ticks_q + 16'd1;
                        end
                        if (longint'(ticks_q) >= ticks_of(SLP_SUSTAIN) && !key) begin
                            ticks_q = 16'd0;
                            stage_q = STG_RELEASE;
                        end
                    end
                    STG_DONE: accum_q = 0;
                    default: ;
                endcase
            end
            amp_expected.push_back(accum_q[FRAC_BITS +: 16]);
            stage_expected.push_back(stage_q);
        endfunction

        function void check_result(logic [15:0] amp, logic [2:0] stg);
            logic [15:0] exp_amp;
            logic [2:0]  exp_stage;
            if (amp_expected.size() == 0) begin
                $error("result with no transfer waiting: amplitude %0d stage %0d", amp, stg);
                n_errors++;
                return;
            end
            exp_amp   = amp_expected.pop_front();
            exp_stage = stage_expected.pop_front();
            n_checked++;
            if (exp_stage == STG_DONE)
                n_finished++;
            if (amp !== exp_amp) begin
                $error("amplitude mismatch: expected %0d, actual %0d", exp_amp, amp);
                n_errors++;
            end
            if (stg !== exp_stage) begin
                $error("stage mismatch: expected %0d, actual %0d", exp_stage, stg);
                n_errors++;
            end
        endfunction
    endclass

    envelope_scoreboard sb;

    four_stage_envelope_generator #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_key_held  (i_key_held),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_amplitude (o_amplitude),
        .o_stage     (o_stage),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // results first: a result never belongs to a transfer of the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_result(o_amplitude, o_stage);
            if (i_in_valid && o_in_ready)
                sb.note_input(i_op, i_key_held);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    // result side
    initial begin
        int stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (long_hold) begin
                long_hold = 1'b0;
                stall = LONG_HOLD;
            end else if (no_idle) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 5);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send_item(input logic op, input logic key);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_key_held <= key;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic load_settings();
        int i;
        for (i = CFG_ATTACK_LEVEL; i <= CFG_RELEASE_TICKS; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= 3'(i);
            i_cfg_data  <= next_regs[3'(i)];
            sb.write_reg(3'(i), next_regs[3'(i)]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [15:0] random_level();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly short stages so envelopes run to the end
    function automatic logic [15:0] random_ticks();
        case ($urandom_range(0, 19))
            0: return 16'd0;
            1: return 16'hFFFF;
            2, 3: return 16'd1;
            default: return 16'($urandom_range(1, 24));
        endcase
    endfunction

    task automatic pick_settings(input bit extreme);
        int i;
        for (i = CFG_ATTACK_LEVEL; i <= CFG_BASE_LEVEL; i++)
            next_regs[3'(i)] = extreme ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)
                                       : random_level();
        for (i = CFG_ATTACK_TICKS; i <= CFG_RELEASE_TICKS; i++)
            next_regs[3'(i)] = random_ticks();
    endtask

    // restart then a run of ticks with the key held for a random part, some noise between
    task automatic random_phase(input int n_items);
        int sent;
        int len;
        int hold;
        int k;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                sent++;
            end else begin
                len  = $urandom_range(8, 60);
                hold = $urandom_range(0, len);
                send_item(OP_RESTART, 1'($urandom_range(0, 1)));
                sent++;
                for (k = 0; k < len && sent < n_items; k++) begin
                    send_item(OP_ADVANCE, k < hold);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        int p;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ticks before any restart: zero slopes, amplitude stays at zero, then a restart
        send_item(OP_ADVANCE, 1'b0);
        send_item(OP_ADVANCE, 1'b1);
        send_item(OP_ADVANCE, 1'b0);
        send_item(OP_RESTART, 1'b1);
        send_item(OP_ADVANCE, 1'b1);
        send_item(OP_ADVANCE, 1'b0);
        wait_results();

        // full swings, zero decay ticks, sustain hold then release into finished
        next_regs[CFG_ATTACK_LEVEL]  = 16'hFFFF;
        next_regs[CFG_DECAY_LEVEL]   = 16'h0000;
        next_regs[CFG_SUSTAIN_LEVEL] = 16'hFFFF;
        next_regs[CFG_BASE_LEVEL]    = 16'h0000;
        next_regs[CFG_ATTACK_TICKS]  = 16'd1;
        next_regs[CFG_DECAY_TICKS]   = 16'd0;
        next_regs[CFG_SUSTAIN_TICKS] = 16'd2;
        next_regs[CFG_RELEASE_TICKS] = 16'd1;
        load_settings();
        send_item(OP_RESTART, 1'b1);
        send_item(OP_ADVANCE, 1'b1);
        send_item(OP_ADVANCE, 1'b1);
        send_item(OP_ADVANCE, 1'b1);
        send_item(OP_ADVANCE, 1'b1);
        send_item(OP_ADVANCE, 1'b1);
        send_item(OP_ADVANCE, 1'b1);
        send_item(OP_ADVANCE, 1'b0);
        send_item(OP_ADVANCE, 1'b0);
        send_item(OP_ADVANCE, 1'b0);
        send_item(OP_ADVANCE, 1'b1);
        wait_results();

        // falling attack from a full base, longest stages
        next_regs[CFG_ATTACK_LEVEL]  = 16'h0000;
        next_regs[CFG_DECAY_LEVEL]   = 16'hFFFF;
        next_regs[CFG_SUSTAIN_LEVEL] = 16'h0000;
        next_regs[CFG_BASE_LEVEL]    = 16'hFFFF;
        next_regs[CFG_ATTACK_TICKS]  = 16'hFFFF;
        next_regs[CFG_DECAY_TICKS]   = 16'hFFFF;
        next_regs[CFG_SUSTAIN_TICKS] = 16'hFFFF;
        next_regs[CFG_RELEASE_TICKS] = 16'hFFFF;
        load_settings();
        send_item(OP_RESTART, 1'b0);
        send_item(OP_ADVANCE, 1'b0);
        send_item(OP_ADVANCE, 1'b1);
        wait_results();

        // new settings land mid-envelope, so lowered and raised ticks both occur
        for (p = 0; p < 6; p++) begin
            pick_settings(p == 3);
            load_settings();
            no_idle   = (p == 1);
            long_hold = (p == 2);
            random_phase(PHASE_ITEMS);
            wait_results();
        end
        no_idle = 1'b0;

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d transfers in (%0d restarts) over %0d register settings",
                 sb.n_inputs, sb.n_restarts, n_settings);
        $display("checked %0d results, %0d of them in the finished stage, %0d errors",
                 sb.n_checked, sb.n_finished, sb.n_errors);
        if (sb.n_errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### four_stage_envelope_generator.f
rtl/fse_pkg.sv
rtl/fse_ctrl.sv
rtl/fse_datapath.sv
rtl/four_stage_envelope_generator.sv
verif/four_stage_envelope_generator_tb.sv
